>>> src/nnrt_pkg.sv
// Shared widths, request codes and sequencer states for the node registry table.
package nnrt_pkg;

   localparam int NODE_ENTRIES_DEFAULT = 16;
   localparam int UID_W                = 32;
   localparam int NODE_NUM_W           = 5;
   localparam int ACK_W                = 8;
   localparam int REQ_W                = 4;
   localparam int COUNT_W              = 5;
   localparam int NUM_SPACE            = 1 << NODE_NUM_W;

   typedef enum logic [REQ_W-1:0] {
      REQ_CLEAR_IDS   = 4'd0,
      REQ_CLEAR_ACKS  = 4'd1,
      REQ_INSERT      = 4'd2,
      REQ_SET_ACK     = 4'd3,
      REQ_REPLACE_ACK = 4'd4,
      REQ_COUNT       = 4'd5,
      REQ_COUNT_ACK   = 4'd6,
      REQ_CHECK       = 4'd7,
      REQ_ASSIGN      = 4'd8
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEARCH,
      ST_FINISH
   } state_type;

endpackage

>>> src/network_node_registry_table.sv
// Registry of remote network nodes: table, scan sequencer and result register.
//
//   channel   direction   handshake                      payload
//   req       in          req_valid / req_stall          req_type, unique_id, node_number,
//                                                        ack_code, new_ack_code
//   rsp       out         rsp_valid / rsp_stall          node_count, is_valid_remote,
//                                                        free_number, table_full
//   csr       in          csr_write_enable               csr_write_data (own node number)
//
// Each request walks the table one entry a cycle, and the assign request then goes on
// searching the held-number mask for a free number.
// Reset (synchronous) empties the whole table at once; no clearing pass follows.
// req_stall is high while a request is in work. A held result does not block the
// next request; the sequencer only waits at its last cycle while rsp_stall holds
// the previous result.
module network_node_registry_table
   #(parameter int NODE_ENTRIES = nnrt_pkg::NODE_ENTRIES_DEFAULT)
   (input  logic                             clock,
    input  logic                             reset,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [nnrt_pkg::REQ_W-1:0]       req_type,
    input  logic [nnrt_pkg::UID_W-1:0]       req_unique_id,
    input  logic [nnrt_pkg::NODE_NUM_W-1:0]  req_node_number,
    input  logic [nnrt_pkg::ACK_W-1:0]       req_ack_code,
    input  logic [nnrt_pkg::ACK_W-1:0]       req_new_ack_code,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [nnrt_pkg::COUNT_W-1:0]     rsp_node_count,
    output logic                             rsp_is_valid_remote,
    output logic [nnrt_pkg::NODE_NUM_W-1:0]  rsp_free_number,
    output logic                             rsp_table_full,
    input  logic                             csr_write_enable,
    input  logic [nnrt_pkg::NODE_NUM_W-1:0]  csr_write_data);

   import nnrt_pkg::*;

   localparam int IDX_W  = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
   localparam int CAND_W = $clog2(NODE_ENTRIES + 1);

   // table
   logic [UID_W-1:0]      uid_ff [NODE_ENTRIES];
   logic [NODE_NUM_W-1:0] num_ff [NODE_ENTRIES];
   logic [ACK_W-1:0]      ack_ff [NODE_ENTRIES];

   // single table write port
   logic                  wr_uid_en;
   logic                  wr_num_en;
   logic                  wr_ack_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [UID_W-1:0]      wr_uid;
   logic [NODE_NUM_W-1:0] wr_num;
   logic [ACK_W-1:0]      wr_ack;

   state_type             state_ff, state_in;
   logic [NODE_NUM_W-1:0] own_ff;

   logic [REQ_W-1:0]      req_ff, req_in;
   logic [UID_W-1:0]      uid_req_ff, uid_req_in;
   logic [NODE_NUM_W-1:0] num_req_ff, num_req_in;
   logic [ACK_W-1:0]      ack_req_ff, ack_req_in;
   logic [ACK_W-1:0]      nack_req_ff, nack_req_in;

   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CAND_W-1:0]     cand_ff, cand_in;
   logic                  hit_ff, hit_in;
   logic                  empty_seen_ff, empty_seen_in;
   logic [IDX_W-1:0]      empty_idx_ff, empty_idx_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [NUM_SPACE-1:0]  mask_ff, mask_in;
   logic [NODE_NUM_W-1:0] free_ff, free_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_remote_ff, rsp_remote_in;
   logic [NODE_NUM_W-1:0] rsp_free_ff, rsp_free_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic                  accept;
   logic                  out_free;
   logic                  last_idx;
   logic                  last_cand;
   logic [UID_W-1:0]      cur_uid;
   logic [NODE_NUM_W-1:0] cur_num;
   logic [ACK_W-1:0]      cur_ack;
   logic [NODE_NUM_W-1:0] cand_num;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_idx  = (idx_ff == IDX_W'(NODE_ENTRIES - 1));
   assign last_cand = (cand_ff == CAND_W'(NODE_ENTRIES));
   assign cur_uid   = uid_ff[idx_ff];
   assign cur_num   = num_ff[idx_ff];
   assign cur_ack   = ack_ff[idx_ff];
   assign cand_num  = NODE_NUM_W'(cand_ff);

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_node_count      = rsp_count_ff;
   assign rsp_is_valid_remote = rsp_remote_ff;
   assign rsp_free_number     = rsp_free_ff;
   assign rsp_table_full      = rsp_full_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_idx) begin
               state_in = (req_ff == REQ_ASSIGN) ? ST_SEARCH : ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (last_cand) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and table writes
   always_comb begin
      req_in        = req_ff;
      uid_req_in    = uid_req_ff;
      num_req_in    = num_req_ff;
      ack_req_in    = ack_req_ff;
      nack_req_in   = nack_req_ff;
      idx_in        = idx_ff;
      cand_in       = cand_ff;
      hit_in        = hit_ff;
      empty_seen_in = empty_seen_ff;
      empty_idx_in  = empty_idx_ff;
      count_in      = count_ff;
      mask_in       = mask_ff;
      free_in       = free_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_remote_in = rsp_remote_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_uid_en     = 1'b0;
      wr_num_en     = 1'b0;
      wr_ack_en     = 1'b0;
      wr_idx        = idx_ff;
      wr_uid        = '0;
      wr_num        = '0;
      wr_ack        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in        = req_type;
               uid_req_in    = req_unique_id;
               num_req_in    = req_node_number;
               ack_req_in    = req_ack_code;
               nack_req_in   = req_new_ack_code;
               idx_in        = '0;
               cand_in       = CAND_W'(1);
               hit_in        = 1'b0;
               empty_seen_in = 1'b0;
               empty_idx_in  = '0;
               count_in      = '0;
               mask_in       = '0;
               free_in       = '0;
            end
         end
         ST_SCAN: begin
            case (req_code_type'(req_ff))
               REQ_CLEAR_IDS: begin
                  wr_uid_en = 1'b1;
                  wr_num_en = 1'b1;
               end
               REQ_CLEAR_ACKS: begin
                  wr_ack_en = 1'b1;
               end
               REQ_INSERT: begin
                  if (!hit_ff && cur_uid == uid_req_ff) begin
                     wr_num_en = 1'b1;
                     wr_num    = num_req_ff;
                     hit_in    = 1'b1;
                  end
                  if (!empty_seen_ff && cur_uid == '0) begin
                     empty_seen_in = 1'b1;
                     empty_idx_in  = idx_ff;
                  end
               end
               REQ_SET_ACK: begin
                  if (!hit_ff && cur_num == num_req_ff) begin
                     wr_ack_en = 1'b1;
                     wr_ack    = ack_req_ff;
                     hit_in    = 1'b1;
                  end
               end
               REQ_REPLACE_ACK: begin
                  if (cur_ack == ack_req_ff) begin
                     wr_ack_en = 1'b1;
                     wr_ack    = nack_req_ff;
                  end
               end
               REQ_COUNT: begin
                  if (cur_num != '0) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               REQ_COUNT_ACK: begin
                  if (cur_num != '0 && cur_ack == ack_req_ff) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               REQ_CHECK: begin
                  if (cur_num == num_req_ff) begin
                     hit_in = 1'b1;
                  end
               end
               REQ_ASSIGN: begin
                  mask_in[cur_num] = 1'b1;
               end
               default: begin
               end
            endcase
            idx_in = last_idx ? '0 : idx_ff + IDX_W'(1);
         end
         ST_SEARCH: begin
            if (!hit_ff && !mask_ff[cand_num] && cand_num != own_ff) begin
               hit_in  = 1'b1;
               free_in = cand_num;
            end
            cand_in = cand_ff + CAND_W'(1);
         end
         ST_FINISH: begin
            if (out_free) begin
               if (req_ff == REQ_INSERT && !hit_ff && empty_seen_ff) begin
                  wr_uid_en = 1'b1;
                  wr_num_en = 1'b1;
                  wr_idx    = empty_idx_ff;
                  wr_uid    = uid_req_ff;
                  wr_num    = num_req_ff;
               end
               rsp_valid_in  = 1'b1;
               rsp_count_in  = count_ff;
               rsp_remote_in = (req_ff == REQ_CHECK) && hit_ff && (num_req_ff != own_ff);
               rsp_free_in   = free_ff;
               rsp_full_in   = (req_ff == REQ_INSERT) && !hit_ff && !empty_seen_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NODE_ENTRIES; i++) begin
            uid_ff[i] <= '0;
            num_ff[i] <= '0;
            ack_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            own_ff <= csr_write_data;
         end
         if (wr_uid_en) begin
            uid_ff[wr_idx] <= wr_uid;
         end
         if (wr_num_en) begin
            num_ff[wr_idx] <= wr_num;
         end
         if (wr_ack_en) begin
            ack_ff[wr_idx] <= wr_ack;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      uid_req_ff    <= uid_req_in;
      num_req_ff    <= num_req_in;
      ack_req_ff    <= ack_req_in;
      nack_req_ff   <= nack_req_in;
      idx_ff        <= idx_in;
      cand_ff       <= cand_in;
      hit_ff        <= hit_in;
      empty_seen_ff <= empty_seen_in;
      empty_idx_ff  <= empty_idx_in;
      count_ff      <= count_in;
      mask_ff       <= mask_in;
      free_ff       <= free_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_remote_ff <= rsp_remote_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_full_ff   <= rsp_full_in;
   end

endmodule
